@@ hdl/keypad_hold_debounce_core_defines.svh @@
`ifndef KEYPAD_HOLD_DEBOUNCE_CORE_DEFINES_SVH
`define KEYPAD_HOLD_DEBOUNCE_CORE_DEFINES_SVH

// same-cycle implication
`define KHD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keypad debounce check failed");

// next-cycle implication
`define KHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keypad debounce check failed");

`endif

@@ hdl/khd_pkg.sv @@
package khd_pkg;

	localparam int unsigned NUM_KEYS = 15;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_HOLD_THRESHOLD = 2'd0;
	localparam cfg_idx_t CFG_RELEASE_TICKS  = 2'd1;

	// column-major scan order of key codes
	localparam logic [3:0] SCAN_CODES [NUM_KEYS] = '{
		4'd1, 4'd4, 4'd7, 4'd10, 4'd13,
		4'd2, 4'd5, 4'd8, 4'd11, 4'd14,
		4'd3, 4'd6, 4'd9, 4'd12, 4'd15
	};

	localparam logic [7:0] HOLD_THRESHOLD_RST = 8'd50;
	localparam logic [7:0] RELEASE_TICKS_RST  = 8'd10;

	typedef struct packed {
		logic [7:0] countdown;
		logic [3:0] latched;
		logic [7:0] count;
		logic [3:0] pending;
	} khd_state_t;

endpackage

@@ hdl/khd_next.sv @@
module khd_next import khd_pkg::*; (
	input  khd_state_t                 cur,
	input  logic       [NUM_KEYS-1:0]  pressed,
	input  logic                       taken,
	input  logic       [7:0]           hold_threshold,
	input  logic       [7:0]           release_ticks,
	output khd_state_t                 nxt
);

	logic [7:0] below;
	logic       gate;
	logic       any_pressed;
	logic [3:0] first_code;
	logic [3:0] last_code;
	logic [3:0] n_pressed;
	logic [8:0] cnt_sum;
	logic [7:0] cnt_sat;
	khd_state_t det;
	logic [3:0] pend0;

	always_comb begin
		below       = release_ticks - 8'd1;
		gate        = (cur.countdown == below) || (cur.countdown == 8'd0);
		any_pressed = |pressed;

		first_code = 4'd0;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (pressed[SCAN_CODES[i] - 4'd1])
				first_code = SCAN_CODES[i];
		end
		last_code = 4'd0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (pressed[SCAN_CODES[i] - 4'd1])
				last_code = SCAN_CODES[i];
		end
		n_pressed = 4'd0;
		for (int i = 0; i < NUM_KEYS; i++)
			n_pressed = n_pressed + 4'(pressed[i]);

		// zero reload keeps the gate open for every pressed key
		if (release_ticks == 8'd0)
			cnt_sum = {1'b0, cur.count} + {5'd0, n_pressed};
		else
			cnt_sum = {1'b0, cur.count} + 9'd1;
		cnt_sat = cnt_sum[8] ? 8'hFF : cnt_sum[7:0];

		det = cur;
		if (gate && any_pressed) begin
			det.latched   = (release_ticks == 8'd0) ? last_code : first_code;
			det.countdown = release_ticks;
			det.count     = cnt_sat;
		end

		pend0 = taken ? 4'd0 : cur.pending;
		nxt   = det;
		nxt.pending = pend0;
		if (det.count >= hold_threshold && det.countdown == 8'd1 && pend0 == 4'd0)
			nxt.pending = det.latched;

		if (det.countdown != 8'd0) begin
			nxt.countdown = det.countdown - 8'd1;
		end else begin
			nxt.latched = 4'd0;
			nxt.count   = 8'd0;
		end
	end

endmodule

@@ hdl/keypad_hold_debounce_core.sv @@
// channel | direction | handshake          | payload
// in      | sink      | in_valid/in_stall   | key_pressed[14:0], key_taken
// out     | source    | out_valid/out_stall | reported_key[3:0], current_key[3:0]
// cfg     | sink      | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[7:0]
//
// One word per cycle sustained while out is not stalled; a word passes the input
// register, then the state/result register. The state update is one pass of
// logic. Reset clears state and valid flags, not input data, and loads threshold
// 50, release ticks 10. A stalled result holds the state; the input register
// still takes one word, then in_stall rises. cfg_ready is always high.
module keypad_hold_debounce_core import khd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [NUM_KEYS-1:0]  key_pressed,
	input  logic                 key_taken,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [3:0]           reported_key,
	output logic [3:0]           current_key,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  cfg_idx_t             cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0]          hold_threshold_q;
	logic [7:0]          release_ticks_q;
	logic                valid_s1;
	logic [NUM_KEYS-1:0] pressed_s1;
	logic                taken_s1;
	logic                out_valid_q;
	khd_state_t          state_q;
	khd_state_t          state_nxt;
	logic                out_free;
	logic                advance;
	logic                in_take;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_threshold_q <= HOLD_THRESHOLD_RST;
			release_ticks_q  <= RELEASE_TICKS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HOLD_THRESHOLD: hold_threshold_q <= cfg_data;
				CFG_RELEASE_TICKS:  release_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pressed_s1 <= key_pressed;
			taken_s1   <= key_taken;
		end
	end

	khd_next u_next (
		.cur            (state_q),
		.pressed        (pressed_s1),
		.taken          (taken_s1),
		.hold_threshold (hold_threshold_q),
		.release_ticks  (release_ticks_q),
		.nxt            (state_nxt)
	);

	// state only moves when a word enters the result register, so it is the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign reported_key = state_q.pending;
	assign current_key  = state_q.latched;

endmodule

@@ hdl/khd_checker.sv @@
`include "keypad_hold_debounce_core_defines.svh"

module khd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [3:0]           reported_key,
	input logic [3:0]           current_key,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	`KHD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(reported_key) && $stable(current_key))
	`KHD_ASSERT_NEXT(a_in_to_out, clk, arst_n, in_acc, ##1 out_valid)
	`KHD_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	`KHD_ASSERT_NOW(a_cfg_open, clk, arst_n, cfg_valid, cfg_ready)

endmodule

bind keypad_hold_debounce_core khd_checker u_khd_checker (.*);
